// ===== hw/rtl/ple_pkg.sv =====
// shared constants, payload types, status and request codes for the list engine
// no dependencies; imported by every module of the block
package ple_pkg;

  // list geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // field widths of the channel payloads
  localparam int TYPE_W   = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 5;
  localparam int COUNT_W  = 5;

  // internal widths
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_READ   = 3'd2,
    REQ_WRITE  = 3'd3,
    REQ_SEARCH = 3'd4
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_data;
    logic [FOUND_W-1:0]  found_position;
    logic [COUNT_W-1:0]  count;
  } rsp_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FINISH,
    S_PUSH
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic exec;
    logic step;
    logic finish;
    logic push;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/positional_list_engine_core.sv =====
// list engine top: one request in, one response out, n = entries walked
// n is at most DEPTH; a new request is taken only once the response is pushed
// the walk moves one entry per cycle through the entry memory, which has a
// read port and a single write port (read, then shifted write of the word read)
// reset: synchronous; empties the list and drops any pending response
// depends on ple_pkg, ple_controller, ple_datapath
module positional_list_engine_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ple_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ple_pkg::rsp_item_t rsp
);
  import ple_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer
  ple_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and result path
  ple_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

// ===== hw/rtl/ple_datapath.sv =====
// list storage, length register, walk counter and response register
// depends on ple_pkg; driven by ple_controller commands
module ple_datapath (
  input  logic               clk,
  input  logic               rst,
  input  ple_pkg::ctl_cmd_t  cmd,
  output ple_pkg::dp_stat_t  stat,
  input  ple_pkg::req_item_t req,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output ple_pkg::rsp_item_t rsp
);
  import ple_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  req_item_t             req_q;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      lim;
  logic                  down;
  logic                  pend;
  logic [ADDR_W-1:0]     pend_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  status_t               status_q;
  logic [CNT_W-1:0]      found;
  logic [DATA_WIDTH-1:0] rdata_res;

  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;
  logic                  pos_zero;
  logic                  beyond;
  logic                  beyond_ins;
  logic [CNT_W-1:0]      pos_idx;
  logic [CNT_W-1:0]      pos_cnt;
  logic [DATA_WIDTH-1:0] key;
  logic                  ok_q;

  status_t               exec_status;
  logic [CNT_W-1:0]      exec_idx;
  logic [CNT_W-1:0]      exec_lim;
  logic                  exec_down;

  logic                  more;
  logic                  hit;
  logic                  rd_en;
  logic [ADDR_W-1:0]     issue_addr;
  logic                  we;
  logic [ADDR_W-1:0]     wa;
  logic [DATA_WIDTH-1:0] wd;

  // position checks against the current length
  assign pos_x      = CMP_W'(req_q.position);
  assign cnt_x      = CMP_W'(count);
  assign pos_zero   = (req_q.position == '0);
  assign beyond     = (pos_x > cnt_x);
  assign beyond_ins = (pos_x > (cnt_x + 1'b1));
  assign pos_idx    = CNT_W'(pos_x - 1'b1);
  assign pos_cnt    = CNT_W'(pos_x);
  assign key        = req_q.value[DATA_WIDTH-1:0];
  assign ok_q       = (status_q == ST_OK);

  // request decode: status and walk range
  always_comb begin
    exec_status = ST_OK;
    exec_idx    = '0;
    exec_lim    = '0;
    exec_down   = 1'b0;
    case (req_q.req_type)
      REQ_INSERT: begin
        if (pos_zero || beyond_ins) begin
          exec_status = ST_BOUNDS;
        end else if (count == CNT_W'(DEPTH)) begin
          exec_status = ST_FULL;
        end else begin
          exec_idx  = count;
          exec_lim  = pos_idx;
          exec_down = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (count == '0) begin
          exec_status = ST_EMPTY;
        end else if (pos_zero || beyond) begin
          exec_status = ST_BOUNDS;
        end else begin
          exec_idx = pos_cnt;
          exec_lim = count;
        end
      end
      REQ_READ: begin
        if (pos_zero || beyond) begin
          exec_status = ST_BOUNDS;
        end else begin
          exec_idx = pos_idx;
          exec_lim = pos_cnt;
        end
      end
      REQ_WRITE: begin
        if (pos_zero || beyond) begin
          exec_status = ST_BOUNDS;
        end
      end
      REQ_SEARCH: begin
        exec_lim = count;
      end
      default: begin
        exec_status = ST_OK;
      end
    endcase
  end

  // walk: one read issued and one earlier read consumed per cycle
  assign more       = (idx != lim);
  assign issue_addr = down ? ADDR_W'(idx - 1'b1) : ADDR_W'(idx);
  assign hit        = pend && (req_q.req_type == REQ_SEARCH) && (rd_data == key);
  assign rd_en      = cmd.step && more && !hit;

  // walk ends on a search hit or once the last read is being consumed
  assign stat = '{walk_done: (hit || !more), out_free: (!rsp_valid || rsp_ready)};

  // length after the request
  always_comb begin
    count_next = count;
    if (ok_q) begin
      case (req_q.req_type)
        REQ_INSERT: count_next = count + 1'b1;
        REQ_DELETE: count_next = count - 1'b1;
        default:    count_next = count;
      endcase
    end
  end

  // single write port: shifted words during the walk, new value at the end
  always_comb begin
    we = 1'b0;
    wa = pend_addr;
    wd = rd_data;
    if (cmd.step && pend) begin
      case (req_q.req_type)
        REQ_INSERT: begin
          we = 1'b1;
          wa = pend_addr + 1'b1;
        end
        REQ_DELETE: begin
          we = 1'b1;
          wa = pend_addr - 1'b1;
        end
        default: we = 1'b0;
      endcase
    end else if (cmd.finish && ok_q) begin
      case (req_q.req_type)
        REQ_INSERT, REQ_WRITE: begin
          we = 1'b1;
          wa = ADDR_W'(pos_idx);
          wd = key;
        end
        default: we = 1'b0;
      endcase
    end
  end

  // entry storage with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[issue_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        pend <= 1'b0;
      end else if (cmd.step) begin
        pend <= rd_en;
      end
      if (cmd.finish) begin
        count <= count_next;
      end
      if (cmd.push) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request, walk and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      status_q  <= exec_status;
      idx       <= exec_idx;
      lim       <= exec_lim;
      down      <= exec_down;
      found     <= '0;
      rdata_res <= '0;
    end
    if (cmd.step) begin
      if (rd_en) begin
        idx       <= down ? (idx - 1'b1) : (idx + 1'b1);
        pend_addr <= issue_addr;
      end
      if (hit) begin
        found <= CNT_W'(pend_addr) + 1'b1;
      end
      if (pend && (req_q.req_type == REQ_READ)) begin
        rdata_res <= rd_data;
      end
    end
    if (cmd.push) begin
      rsp.status         <= status_q;
      rsp.read_data      <= VALUE_W'(rdata_res);
      rsp.found_position <= FOUND_W'(found);
      rsp.count          <= COUNT_W'(count);
    end
  end

endmodule

// ===== hw/rtl/ple_controller.sv =====
// sequencing state machine for the list engine
// depends on ple_pkg; commands ple_datapath
module ple_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  ple_pkg::dp_stat_t stat,
  output ple_pkg::ctl_cmd_t cmd
);
  import ple_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (stat.walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
